### sv/ntab_pkg.sv
`timescale 1ns / 1ps

package ntab_pkg;

    localparam int MAX_NEIGHBORS = 16;
    localparam int KEY_BYTES     = 8;

    localparam int IDX_W  = $clog2(MAX_NEIGHBORS);
    localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int PORT_W = 16;
    localparam int KEY_W  = 64;
    localparam int LEN_W  = 4;
    localparam int KIND_W = 8;
    localparam int HOLD_W = 16;
    localparam int TIME_W = 64;
    localparam int TICK_W = 32;
    localparam int PROD_W = HOLD_W + 1 + TICK_W;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [KEY_W-1:0]  ckey;
        logic [LEN_W-1:0]  clen;
        logic [KIND_W-1:0] ckind;
        logic [KEY_W-1:0]  rkey;
        logic [LEN_W-1:0]  rlen;
        logic [KIND_W-1:0] rkind;
        logic [HOLD_W-1:0] hold;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_AGED     = 2'd3
    } t_status;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : len;
    endfunction

    function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] key,
                                                 input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (b < int'(len)) begin
                m[b*8 +: 8] = key[b*8 +: 8];
            end
        end
        return m;
    endfunction

endpackage

### sv/ntab_ram.sv
`timescale 1ns / 1ps

module ntab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/neighbor_table_with_aging_unit.sv
`timescale 1ns / 1ps

// Neighbor table with hold-time aging.
// Command channel: an item is taken at a clock edge with start high and busy
// low; busy stays high until the result is out. Each item gives one result,
// shown for one cycle with o_valid high; the receiver cannot stall it.
// Add item: the table is searched one entry at a time through the RAM read port,
// each entry read (S_RD) and then compared (S_CMP). A hit updates that entry
// and ends the search; a miss on every entry, or an empty table, goes to the
// insert step (S_INS), which inserts at the table end or reports table full.
// Age item: each entry checked goes through read, multiply (hold+1)*tick_rate
// and compare against now - stamp; a removal moves the last entry down in place
// of its read and rechecks it. For an age item with tick_rate zero or an empty
// table the result is loaded at the accepting edge itself.
// Configuration: i_cfg_we writes tick_rate at once; write only while idle.
// Reset empties the table and clears tick_rate; the RAM contents are left as
// they are, since only entries below the valid count are ever read.
// busy is low again in the cycle that shows a result, so the next item may be
// taken at the same edge that takes the result.

module neighbor_table_with_aging_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_req_type,
    input  logic [ntab_pkg::PORT_W-1:0]       i_port_number,
    input  logic [ntab_pkg::KEY_W-1:0]        i_chassis_key,
    input  logic [ntab_pkg::LEN_W-1:0]        i_chassis_key_len,
    input  logic [ntab_pkg::KIND_W-1:0]       i_chassis_kind,
    input  logic [ntab_pkg::KEY_W-1:0]        i_remote_port_key,
    input  logic [ntab_pkg::LEN_W-1:0]        i_remote_port_len,
    input  logic [ntab_pkg::KIND_W-1:0]       i_remote_port_kind,
    input  logic [ntab_pkg::HOLD_W-1:0]       i_hold_time,
    input  logic [ntab_pkg::TIME_W-1:0]       i_now_time,
    input  logic                              i_cfg_we,
    input  logic [ntab_pkg::TICK_W-1:0]       i_cfg_wdata,
    output logic                              o_valid,
    output logic [1:0]                        o_status,
    output logic [ntab_pkg::IDX_W-1:0]        o_slot_index,
    output logic [ntab_pkg::CNT_W-1:0]        o_valid_count,
    output logic [ntab_pkg::CNT_W-1:0]        o_removed_count
);

    import ntab_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_INS,
        S_ARD,
        S_AMUL,
        S_ACMP,
        S_AMOV
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_count;
    logic [TICK_W-1:0] r_tick;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_removed;
    t_entry            r_item;
    logic [PROD_W-1:0] r_prod;
    logic [TIME_W-1:0] r_diff;
    logic              r_valid;
    logic [1:0]        r_status;
    logic [IDX_W-1:0]  r_slot;
    logic [CNT_W-1:0]  r_vcount;
    logic [CNT_W-1:0]  r_rcount;

    t_entry            w_rdata;
    logic [ENTRY_W-1:0] w_rdata_bits;
    t_entry            w_wdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic              w_re;
    logic [IDX_W-1:0]  w_raddr;
    logic              w_match;
    logic              w_expired;
    logic              w_last;
    logic              w_full;
    logic [CNT_W-1:0]  w_count_m1;
    t_entry            w_new;
    logic [LEN_W-1:0]  w_clen;
    logic [LEN_W-1:0]  w_rlen;

    assign w_rdata    = t_entry'(w_rdata_bits);
    assign w_count_m1 = r_count - CNT_W'(1);
    assign w_last     = ({1'b0, r_idx} == w_count_m1);
    assign w_full     = (r_count >= CNT_W'(MAX_NEIGHBORS));
    assign w_match    = (w_rdata.port == r_item.port) && (w_rdata.clen == r_item.clen) &&
                        (w_rdata.ckey == r_item.ckey);
    assign w_expired  = (r_diff >= {{(TIME_W - PROD_W){1'b0}}, r_prod});

    always_comb begin
        w_clen      = clamp_len(i_chassis_key_len);
        w_rlen      = clamp_len(i_remote_port_len);
        w_new.port  = i_port_number;
        w_new.ckey  = mask_key(i_chassis_key, w_clen);
        w_new.clen  = w_clen;
        w_new.ckind = i_chassis_kind;
        w_new.rkey  = mask_key(i_remote_port_key, w_rlen);
        w_new.rlen  = w_rlen;
        w_new.rkind = i_remote_port_kind;
        w_new.hold  = i_hold_time;
        w_new.stamp = i_now_time;
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_rdata;
        case (r_state)
            S_RD, S_ARD: begin
                w_re = 1'b1;
            end
            S_CMP: begin
                w_we          = w_match;
                w_wdata.rkey  = r_item.rkey;
                w_wdata.rlen  = r_item.rlen;
                w_wdata.rkind = r_item.rkind;
                w_wdata.hold  = r_item.hold;
                w_wdata.stamp = r_item.stamp;
            end
            S_INS: begin
                w_we    = !w_full;
                w_waddr = r_count[IDX_W-1:0];
                w_wdata = r_item;
            end
            S_ACMP: begin
                w_re    = w_expired && !w_last;
                w_raddr = w_count_m1[IDX_W-1:0];
            end
            S_AMOV: begin
                w_we = 1'b1;
            end
            default: begin
                w_re = 1'b0;
            end
        endcase
    end

    ntab_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_NEIGHBORS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_tick  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item    <= w_new;
                        r_idx     <= '0;
                        r_removed <= '0;
                        if (!i_req_type) begin
                            r_state <= (r_count == '0) ? S_INS : S_RD;
                        end else if (r_tick == '0 || r_count == '0) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_AGED;
                            r_slot   <= '0;
                            r_vcount <= r_count;
                            r_rcount <= '0;
                        end else begin
                            r_state <= S_ARD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_match) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_UPDATED;
                        r_slot   <= r_idx;
                        r_vcount <= r_count;
                        r_rcount <= '0;
                        r_state  <= S_IDLE;
                    end else if (w_last) begin
                        r_state <= S_INS;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_RD;
                    end
                end
                S_INS: begin
                    r_valid  <= 1'b1;
                    r_rcount <= '0;
                    r_state  <= S_IDLE;
                    if (w_full) begin
                        r_status <= ST_FULL;
                        r_slot   <= '0;
                        r_vcount <= r_count;
                    end else begin
                        r_status <= ST_INSERTED;
                        r_slot   <= r_count[IDX_W-1:0];
                        r_vcount <= r_count + CNT_W'(1);
                        r_count  <= r_count + CNT_W'(1);
                    end
                end
                S_ARD: begin
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_prod  <= ({1'b0, w_rdata.hold} + (HOLD_W + 1)'(1)) * r_tick;
                    r_diff  <= r_item.stamp - w_rdata.stamp;
                    r_state <= S_ACMP;
                end
                S_ACMP: begin
                    if (w_expired) begin
                        r_removed <= r_removed + CNT_W'(1);
                        if (w_last) begin
                            r_count  <= w_count_m1;
                            r_valid  <= 1'b1;
                            r_status <= ST_AGED;
                            r_slot   <= '0;
                            r_vcount <= w_count_m1;
                            r_rcount <= r_removed + CNT_W'(1);
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_AMOV;
                        end
                    end else if (w_last) begin
                        r_valid  <= 1'b1;
                        r_status <= ST_AGED;
                        r_slot   <= '0;
                        r_vcount <= r_count;
                        r_rcount <= r_removed;
                        r_state  <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_ARD;
                    end
                end
                S_AMOV: begin
                    r_count <= w_count_m1;
                    r_state <= S_AMUL;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_slot_index    = r_slot;
    assign o_valid_count   = r_vcount;
    assign o_removed_count = r_rcount;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_NEIGHBORS))
        else $error("valid count beyond table size");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_AGED |-> $past(busy))
        else $error("add result without search");

    a_add_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_AGED |-> o_removed_count == '0)
        else $error("add item reports removals");

    a_insert_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_INSERTED |->
        o_valid_count == {1'b0, o_slot_index} + CNT_W'(1))
        else $error("inserted slot not at table end");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_valid_count == CNT_W'(MAX_NEIGHBORS))
        else $error("table full reported below capacity");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ntab_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int RAND_PHASES     = 11;
    localparam int ITEMS_PER_PHASE = 148;
    localparam int DRAIN_CYCLES    = 150;
    localparam int POOL_MAX        = 40;

    typedef enum logic {
        REQ_ADD = 1'b0,
        REQ_AGE = 1'b1
    } t_req;

    typedef struct {
        t_req              kind;
        logic [PORT_W-1:0] port;
        logic [KEY_W-1:0]  ckey;
        logic [LEN_W-1:0]  clen;
        logic [KIND_W-1:0] ckind;
        logic [KEY_W-1:0]  rkey;
        logic [LEN_W-1:0]  rlen;
        logic [KIND_W-1:0] rkind;
        logic [HOLD_W-1:0] hold;
        logic [TIME_W-1:0] now;
    } t_nbr_req;

    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] slot;
        logic [CNT_W-1:0] vcount;
        logic [CNT_W-1:0] rcount;
    } t_nbr_res;

    typedef struct {
        bit                is_cfg;
        logic [TICK_W-1:0] tick;
        t_nbr_req          req;
        bit                typed;
        t_nbr_res          res;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_req_type;
    logic [PORT_W-1:0]   i_port_number;
    logic [KEY_W-1:0]    i_chassis_key;
    logic [LEN_W-1:0]    i_chassis_key_len;
    logic [KIND_W-1:0]   i_chassis_kind;
    logic [KEY_W-1:0]    i_remote_port_key;
    logic [LEN_W-1:0]    i_remote_port_len;
    logic [KIND_W-1:0]   i_remote_port_kind;
    logic [HOLD_W-1:0]   i_hold_time;
    logic [TIME_W-1:0]   i_now_time;
    logic                i_cfg_we;
    logic [TICK_W-1:0]   i_cfg_wdata;
    logic                o_valid;
    logic [1:0]          o_status;
    logic [IDX_W-1:0]    o_slot_index;
    logic [CNT_W-1:0]    o_valid_count;
    logic [CNT_W-1:0]    o_removed_count;

    t_entry            nbr_table [MAX_NEIGHBORS];
    int                nbr_count = 0;
    logic [TICK_W-1:0] aging_tick = '0;
    t_nbr_res          pending_results [$];
    t_dir_row          dir_rows [$];
    t_nbr_res          no_res;
    int                err_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;

    neighbor_table_with_aging_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_port_number      (i_port_number),
        .i_chassis_key      (i_chassis_key),
        .i_chassis_key_len  (i_chassis_key_len),
        .i_chassis_kind     (i_chassis_kind),
        .i_remote_port_key  (i_remote_port_key),
        .i_remote_port_len  (i_remote_port_len),
        .i_remote_port_kind (i_remote_port_kind),
        .i_hold_time        (i_hold_time),
        .i_now_time         (i_now_time),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_slot_index       (o_slot_index),
        .o_valid_count      (o_valid_count),
        .o_removed_count    (o_removed_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
        if (len >= LEN_W'(KEY_BYTES)) begin
            return '1;
        end
        return (KEY_W'(1) << (8 * len)) - KEY_W'(1);
    endfunction

    function automatic t_nbr_res predict_neighbor(input t_nbr_req r);
        t_nbr_res          e;
        logic [LEN_W-1:0]  cl;
        logic [LEN_W-1:0]  rl;
        logic [KEY_W-1:0]  ck;
        logic [KEY_W-1:0]  rk;
        logic [TIME_W-1:0] secs;
        int                hit;
        int                k;
        e.status = ST_AGED;
        e.slot   = '0;
        e.rcount = '0;
        if (r.kind == REQ_ADD) begin
            cl  = (r.clen > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : r.clen;
            rl  = (r.rlen > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : r.rlen;
            ck  = r.ckey & key_mask(cl);
            rk  = r.rkey & key_mask(rl);
            hit = -1;
            for (k = 0; k < nbr_count; k++) begin
                if (hit < 0 && nbr_table[k].port == r.port && nbr_table[k].clen == cl &&
                    nbr_table[k].ckey == ck) begin
                    hit = k;
                end
            end
            if (hit >= 0) begin
                nbr_table[hit].rkey  = rk;
                nbr_table[hit].rlen  = rl;
                nbr_table[hit].rkind = r.rkind;
                nbr_table[hit].hold  = r.hold;
                nbr_table[hit].stamp = r.now;
                e.status = ST_UPDATED;
                e.slot   = IDX_W'(hit);
            end else if (nbr_count >= MAX_NEIGHBORS) begin
                e.status = ST_FULL;
            end else begin
                nbr_table[nbr_count] = '{port: r.port, ckey: ck, clen: cl, ckind: r.ckind,
                                         rkey: rk, rlen: rl, rkind: r.rkind,
                                         hold: r.hold, stamp: r.now};
                e.status = ST_INSERTED;
                e.slot   = IDX_W'(nbr_count);
                nbr_count++;
            end
        end else if (aging_tick != '0) begin
            k = 0;
            while (k < nbr_count) begin
                secs = (r.now - nbr_table[k].stamp) / TIME_W'(aging_tick);
                if (secs > TIME_W'(nbr_table[k].hold)) begin
                    nbr_table[k] = nbr_table[nbr_count - 1];
                    nbr_count--;
                    e.rcount++;
                end else begin
                    k++;
                end
            end
        end
        e.vcount = CNT_W'(nbr_count);
        return e;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        t_nbr_res want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, status", o_status, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_slot_index !== want.slot)
                    report_mismatch("slot_index", o_slot_index, want.slot);
                if (o_valid_count !== want.vcount)
                    report_mismatch("valid_count", o_valid_count, want.vcount);
                if (o_removed_count !== want.rcount)
                    report_mismatch("removed_count", o_removed_count, want.rcount);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input t_nbr_req r, input bit typed, input t_nbr_res typed_res);
        t_nbr_res e;
        int       gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 4) == 0) begin
                burst_left = 40;
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 6);
            end
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_req_type         <= r.kind;
        i_port_number      <= r.port;
        i_chassis_key      <= r.ckey;
        i_chassis_key_len  <= r.clen;
        i_chassis_kind     <= r.ckind;
        i_remote_port_key  <= r.rkey;
        i_remote_port_len  <= r.rlen;
        i_remote_port_kind <= r.rkind;
        i_hold_time        <= r.hold;
        i_now_time         <= r.now;
        start              <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (busy === 1'b0) break;
        end
        e = predict_neighbor(r);
        pending_results.push_back(typed ? typed_res : e);
        @(negedge i_clk);
    endtask

    task automatic write_tick_rate(input logic [TICK_W-1:0] v);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        aging_tick = v;
    endtask

    task automatic row_add(input logic [PORT_W-1:0] port, input logic [KEY_W-1:0] ckey,
                           input logic [LEN_W-1:0] clen, input logic [KIND_W-1:0] ckind,
                           input logic [KEY_W-1:0] rkey, input logic [LEN_W-1:0] rlen,
                           input logic [KIND_W-1:0] rkind, input logic [HOLD_W-1:0] hold,
                           input logic [TIME_W-1:0] now);
        t_dir_row row;
        row.is_cfg    = 1'b0;
        row.tick      = '0;
        row.typed     = 1'b0;
        row.req.kind  = REQ_ADD;
        row.req.port  = port;
        row.req.ckey  = ckey;
        row.req.clen  = clen;
        row.req.ckind = ckind;
        row.req.rkey  = rkey;
        row.req.rlen  = rlen;
        row.req.rkind = rkind;
        row.req.hold  = hold;
        row.req.now   = now;
        dir_rows.push_back(row);
    endtask

    task automatic row_age(input logic [TIME_W-1:0] now);
        row_add('0, '0, '0, '0, '0, '0, '0, '0, now);
        dir_rows[dir_rows.size() - 1].req.kind = REQ_AGE;
    endtask

    task automatic row_cfg(input logic [TICK_W-1:0] tick);
        t_dir_row row;
        row.is_cfg = 1'b1;
        row.tick   = tick;
        row.typed  = 1'b0;
        dir_rows.push_back(row);
    endtask

    task automatic row_expect(input t_status st, input int slot, input int vc, input int rc);
        int n;
        n = dir_rows.size() - 1;
        dir_rows[n].typed      = 1'b1;
        dir_rows[n].res.status = st;
        dir_rows[n].res.slot   = IDX_W'(slot);
        dir_rows[n].res.vcount = CNT_W'(vc);
        dir_rows[n].res.rcount = CNT_W'(rc);
    endtask

    initial begin
        t_nbr_req          r;
        logic [PORT_W-1:0] pool_port [POOL_MAX];
        logic [KEY_W-1:0]  pool_key [POOL_MAX];
        logic [LEN_W-1:0]  pool_len [POOL_MAX];
        logic [TIME_W-1:0] clock_ticks;
        logic [TICK_W-1:0] tick;
        int                pool_size;
        int                hold_max;
        int                adv_max;
        int                roll;
        int                ph;
        int                n;
        int                k;

        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_req_type         = REQ_ADD;
        i_port_number      = '0;
        i_chassis_key      = '0;
        i_chassis_key_len  = '0;
        i_chassis_kind     = '0;
        i_remote_port_key  = '0;
        i_remote_port_len  = '0;
        i_remote_port_kind = '0;
        i_hold_time        = '0;
        i_now_time         = '0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        clock_ticks        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        row_age(64'd0);
        row_expect(ST_AGED, 0, 0, 0);
        row_add(16'd0, 64'd0, 4'd0, 8'd0, 64'd0, 4'd0, 8'd0, 16'd0, 64'd0);
        row_expect(ST_INSERTED, 0, 1, 0);
        row_add(16'hFFFF, '1, 4'hF, 8'hFF, '1, 4'hF, 8'hFF, 16'hFFFF, '1);
        row_expect(ST_INSERTED, 1, 2, 0);
        row_add(16'hFFFF, '1, 4'd8, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd9, 8'h5A, 16'hFFFF, '1);
        row_expect(ST_UPDATED, 1, 2, 0);
        row_add(16'd0, 64'h1234, 4'd0, 8'h11, 64'hFFFF, 4'd1, 8'h22, 16'd0, 64'd0);
        row_expect(ST_UPDATED, 0, 2, 0);
        row_add(16'd5, 64'hAABB_CCDD_1122_3344, 4'd2, 8'h01, 64'h55, 4'd1, 8'h03, 16'd3,
                64'd10);
        row_expect(ST_INSERTED, 2, 3, 0);
        row_add(16'd5, 64'h3344, 4'd2, 8'h02, 64'h66, 4'd1, 8'h03, 16'd3, 64'd10);
        row_expect(ST_UPDATED, 2, 3, 0);
        row_add(16'd5, 64'h3344, 4'd3, 8'h02, 64'h66, 4'd1, 8'h03, 16'd2, 64'd20);
        row_expect(ST_INSERTED, 3, 4, 0);
        row_age('1);
        row_expect(ST_AGED, 0, 4, 0);
        for (k = 0; k < 12; k++) begin
            row_add(PORT_W'(100 + k), {$urandom, $urandom}, LEN_W'(k % 10), KIND_W'(k),
                    {$urandom, $urandom}, LEN_W'(k), KIND_W'(k), HOLD_W'(k), TIME_W'(3 * k));
        end
        row_add(16'd200, 64'd0, 4'd0, 8'd0, 64'd0, 4'd0, 8'd0, 16'd9, 64'd0);
        row_expect(ST_FULL, 0, 16, 0);
        row_add(16'd0, 64'hFF, 4'd0, 8'h33, 64'h77, 4'd8, 8'h44, 16'd0, 64'd0);
        row_expect(ST_UPDATED, 0, 16, 0);
        row_cfg(32'd1);
        row_age(64'd5);
        row_cfg(32'hFFFF_FFFF);
        row_age('1);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_tick_rate(dir_rows[i].tick);
            end else begin
                send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 6)
                0: tick = '0;
                1: tick = 32'd1;
                2: tick = '1;
                3: tick = TICK_W'($urandom_range(2, 1000));
                default: tick = $urandom;
            endcase
            write_tick_rate(tick);
            pool_size = $urandom_range(4, POOL_MAX);
            hold_max  = $urandom_range(2, 60);
            adv_max   = $urandom_range(0, 3);
            for (k = 0; k < pool_size; k++) begin
                pool_port[k] = ($urandom_range(0, 3) == 0) ? PORT_W'($urandom)
                                                           : PORT_W'($urandom_range(0, 3));
                pool_key[k]  = {$urandom, $urandom};
                pool_len[k]  = LEN_W'($urandom_range(0, 15));
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (aging_tick != '0) begin
                    clock_ticks += TIME_W'(aging_tick) * $urandom_range(0, adv_max) +
                                   TIME_W'($urandom_range(0, aging_tick));
                end else begin
                    clock_ticks += TIME_W'($urandom_range(0, 1000));
                end
                if ($urandom_range(0, 199) == 0) clock_ticks = {$urandom, $urandom};
                r.kind  = REQ_ADD;
                r.port  = PORT_W'($urandom);
                r.ckey  = {$urandom, $urandom};
                r.clen  = LEN_W'($urandom);
                r.ckind = KIND_W'($urandom);
                r.rkey  = {$urandom, $urandom};
                r.rlen  = LEN_W'($urandom);
                r.rkind = KIND_W'($urandom);
                r.hold  = HOLD_W'($urandom);
                r.now   = clock_ticks;
                roll = $urandom_range(0, 99);
                if (roll < 15) begin
                    r.kind = REQ_AGE;
                end else if (roll < 25) begin
                    if ($urandom_range(0, 1) == 1) r.now = {$urandom, $urandom};
                end else begin
                    k = $urandom_range(0, pool_size - 1);
                    r.port = pool_port[k];
                    r.clen = pool_len[k];
                    r.ckey = (r.ckey & ~key_mask(r.clen)) | (pool_key[k] & key_mask(r.clen));
                    if ($urandom_range(0, 9) != 0) r.hold = HOLD_W'($urandom_range(0, hold_max));
                end
                send_item(r, 1'b0, no_res);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
